@@ sv/bia_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_pkg
// shared constants, types and command/status structs of the id allocator
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int ID_CAPACITY   = 256;
    localparam int ID_W          = 8;
    localparam int ID_LIMIT      = 1 << ID_W;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = $clog2(WORD_W);
    localparam int ROUNDED_CAP   = ((ID_CAPACITY + WORD_W - 1) / WORD_W) * WORD_W;
    localparam int EFFECTIVE_CAP = (ROUNDED_CAP < ID_LIMIT) ? ROUNDED_CAP : ID_LIMIT;
    localparam int NUM_WORDS     = EFFECTIVE_CAP / WORD_W;
    localparam int WIDX_W        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int STATUS_W      = 2;

    typedef enum logic [0:0] {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic advance;
        logic commit_free;
        logic commit_alloc;
    } bia_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic kind_free;
        logic word_full;
        logic last_word;
        logic out_free;
    } bia_stat_t;

endpackage : bia_pkg
`default_nettype wire

@@ sv/bia_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_if
// request and response channels of the id allocator
// ----------------------------------------------------------------------------
interface bia_req_if
    import bia_pkg::*;
();
    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [ID_W-1:0]   id_to_free;

    modport source (output valid, output kind, output id_to_free, input ready);
    modport sink   (input valid, input kind, input id_to_free, output ready);
endinterface : bia_req_if

interface bia_rsp_if
    import bia_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   granted_id;
    status_t           status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink   (input valid, input granted_id, input status, output ready);
endinterface : bia_rsp_if
`default_nettype wire

@@ sv/bia_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_ctrl
// sequencing of request capture, word scan and result commit
// ----------------------------------------------------------------------------
module bia_ctrl
    import bia_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire bia_stat_t stat,
    output bia_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_FREE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit_free = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // first scan cycle also routes a free request away
                if (stat.kind_free)
                begin
                    state_next = S_FREE;
                end
                else if (!stat.word_full || stat.last_word)
                begin
                    if (stat.out_free)
                    begin
                        cmd.commit_alloc = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : bia_ctrl
`default_nettype wire

@@ sv/bia_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_datapath
// used-id bitmap, scan pointer, lowest-clear-bit finder and result register
// ----------------------------------------------------------------------------
module bia_datapath
    import bia_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire kind_t           req_kind,
    input  wire logic [ID_W-1:0] req_id,
    input  wire bia_cmd_t        cmd,
    output bia_stat_t            stat,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output logic [ID_W-1:0]      rsp_id,
    output status_t              rsp_status
);

    logic [WORD_W-1:0] map_reg [NUM_WORDS];
    logic [WORD_W-1:0] map_next [NUM_WORDS];
    logic [WIDX_W-1:0] widx_reg;
    logic [WIDX_W-1:0] widx_next;
    kind_t             kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [ID_W-1:0]   out_id_next;
    status_t           out_status_reg;
    status_t           out_status_next;

    logic [WORD_W-1:0] cur_word;
    logic [WORD_W-1:0] zero_onehot;
    logic [BIT_W-1:0]  zero_pos;
    logic              id_ok;
    logic [WIDX_W-1:0] free_widx;
    logic [BIT_W-1:0]  free_bit;

    function automatic logic req_id_nz(input logic [ID_W-1:0] v);
        return v != '0;
    endfunction

    assign cur_word    = map_reg[widx_reg];
    assign zero_onehot = ~cur_word & (cur_word + WORD_W'(1));

    always_comb
    begin
        zero_pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (zero_onehot[i])
            begin
                zero_pos = zero_pos | BIT_W'(i);
            end
        end
    end

    assign id_ok     = (req_id_nz(id_reg)) &&
                       ({1'b0, id_reg} < (ID_W + 1)'(EFFECTIVE_CAP));
    assign free_widx = WIDX_W'(id_reg[ID_W-1:BIT_W]);
    assign free_bit  = id_reg[BIT_W-1:0];

    assign stat.kind_free = (kind_reg == KIND_FREE);
    assign stat.word_full = &cur_word;
    assign stat.last_word = (widx_reg == WIDX_W'(NUM_WORDS - 1));
    assign stat.out_free  = !out_valid_reg || rsp_ready;

    always_comb
    begin
        map_next        = map_reg;
        widx_next       = widx_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;

        if (cmd.capture)
        begin
            widx_next = '0;
        end
        if (cmd.advance)
        begin
            widx_next = widx_reg + WIDX_W'(1);
        end
        if (cmd.commit_free)
        begin
            out_valid_next = 1'b1;
            out_id_next    = '0;
            if (id_ok)
            begin
                map_next[free_widx] = map_reg[free_widx] & ~(WORD_W'(1) << free_bit);
                out_status_next     = ST_FREED;
            end
            else
            begin
                out_status_next = ST_IGNORED;
            end
        end
        if (cmd.commit_alloc)
        begin
            out_valid_next = 1'b1;
            if (!stat.word_full)
            begin
                map_next[widx_reg] = cur_word | zero_onehot;
                out_id_next        = ID_W'({widx_reg, zero_pos});
                out_status_next    = ST_ALLOCATED;
            end
            else
            begin
                out_id_next     = '0;
                out_status_next = ST_NONE_FREE;
            end
        end
    end

    // bitmap and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                map_reg[w] <= (w == 0) ? WORD_W'(1) : '0;
            end
            widx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            map_reg       <= map_next;
            widx_reg      <= widx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= req_kind;
            id_reg   <= req_id;
        end
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_id     = out_id_reg;
    assign rsp_status = out_status_reg;

endmodule : bia_datapath
`default_nettype wire

@@ sv/bitmap_id_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// a free steps from the scan state to the free state, then commits its result
// an allocate scans the bitmap one word per cycle from word 0 and commits at the
// first word with a clear bit or at the last word; a new request is taken only
// when idle, after the result is committed; a stalled response holds the commit
// reset: bitmap cleared with id 0 reserved, no result pending, ready for a request
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// lowest-free id allocator over a bitmap of used ids held in 32-bit words
// ----------------------------------------------------------------------------
module bitmap_id_allocator
    import bia_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bia_req_if.sink   req,
    bia_rsp_if.source rsp
);

    // command and status between controller and datapath
    bia_cmd_t  cmd;
    bia_stat_t stat;

    // controller: accepts a transfer when idle, then steps the scan
    // and commits once the result register has room
    bia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: bitmap words, scan pointer and the registered result,
    // which lets a new request transfer while a result waits
    bia_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_kind   (req.kind),
        .req_id     (req.id_to_free),
        .cmd        (cmd),
        .stat       (stat),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_id     (rsp.granted_id),
        .rsp_status (rsp.status)
    );

endmodule : bitmap_id_allocator
`default_nettype wire
